@@ sv/pnc_pkg.sv @@
// ----------------------------------------------------------------------------
// pnc_pkg: shared definitions for the chunk peak normalizer
// Sample format, fixed-point constants and the magnitude helper.
// ----------------------------------------------------------------------------
package pnc_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int FRAC_W      = 20;
	localparam int QUOT_W      = FRAC_W + 1;
	localparam int CHUNK_DEPTH = 64;

	localparam logic [SAMPLE_W-1:0] ONE_Q20 = SAMPLE_W'(1) << FRAC_W;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// |v| of a signed Q3.20 word; -2^23 maps to 2^23, still fits unsigned
	function automatic sample_t mag24(input sample_t v);
		sample_t m;
		m = v[SAMPLE_W-1] ? SAMPLE_W'(~v + SAMPLE_W'(1)) : v;
		return m;
	endfunction

endpackage

@@ sv/pnc_store.sv @@
// ----------------------------------------------------------------------------
// pnc_store: chunk sample memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pnc_store #(
	parameter int DEPTH  = pnc_pkg::CHUNK_DEPTH,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  pnc_pkg::sample_t    wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output pnc_pkg::sample_t    rd_data
);

	pnc_pkg::sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/pnc_div.sv @@
// ----------------------------------------------------------------------------
// pnc_div: serial restoring divider
// Computes floor(mag * 2^20 / peak) for mag <= peak, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pnc_pkg::sample_t              dividend,
	input  pnc_pkg::sample_t              divisor,
	output logic                          done,
	output logic [pnc_pkg::QUOT_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(pnc_pkg::FRAC_W + 1);

	pnc_pkg::sample_t          rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [pnc_pkg::QUOT_W-1:0] quot_q;

	logic [pnc_pkg::SAMPLE_W:0] trial;
	logic [pnc_pkg::SAMPLE_W:0] diff;
	logic                       ge;
	logic                       ge0;

	assign trial = {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};
	// integer bit of the quotient: dividend never exceeds divisor
	assign ge0   = dividend >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= ge0 ? pnc_pkg::sample_t'(dividend - divisor) : dividend;
				quot_q <= pnc_pkg::QUOT_W'(ge0);
				cnt_q  <= CNT_W'(pnc_pkg::FRAC_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[pnc_pkg::SAMPLE_W-1:0] : trial[pnc_pkg::SAMPLE_W-1:0];
				quot_q <= {quot_q[pnc_pkg::QUOT_W-2:0], ge};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

@@ sv/peak_normalize_chunk_unit.sv @@
// ----------------------------------------------------------------------------
// peak_normalize_chunk_unit: chunk peak normalizer, Q3.20 audio
// Buffers a chunk, tracks its peak and emits it scaled so |peak| <= 1.0.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the chunk is collected; non-finite
// samples are stored as zero and samples beyond CHUNK_DEPTH are dropped.
// The request carrying tlast starts emission of the stored chunk, during
// which no input is taken. Each output sample is passed on unchanged when
// the peak is at most 1.0 and otherwise scaled by the single serial divider
// that produces one quotient bit per cycle (21 bits); the next sample is read
// only once the output side has taken the current one with tready high.
module peak_normalize_chunk_unit #(
	parameter int CHUNK_DEPTH = pnc_pkg::CHUNK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pnc_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [23:0] sample_in
	input  logic                          s_axis_tuser,   // [0] not_finite
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pnc_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [23:0] sample_out
	output logic                          m_axis_tlast
);

	localparam int ADDR_W = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
	localparam int CNT_W  = $clog2(CHUNK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CHUNK_DEPTH);

	typedef enum logic [2:0] {
		ST_IN,
		ST_RD,
		ST_LD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  idx_q;
	pnc_pkg::sample_t  peak_q;
	logic              neg_q;
	pnc_pkg::sample_t  out_data_q;
	logic              out_last_q;

	logic              in_req;
	logic              wr_en;
	pnc_pkg::sample_t  in_sample;
	pnc_pkg::sample_t  in_mag;
	pnc_pkg::sample_t  rd_data;
	pnc_pkg::sample_t  rd_mag;
	logic              pass;
	logic              div_start;
	logic              div_done;
	logic [pnc_pkg::QUOT_W-1:0] quot;
	pnc_pkg::sample_t  quot_ext;
	pnc_pkg::sample_t  scaled;
	logic              is_last;

	assign s_axis_tready = (state_q == ST_IN);
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign in_sample     = s_axis_tuser ? '0 : s_axis_tdata;
	assign in_mag        = pnc_pkg::mag24(in_sample);
	assign wr_en         = in_req && (fill_q < DEPTH_CNT);

	assign pass      = peak_q <= pnc_pkg::ONE_Q20;
	assign rd_mag    = pnc_pkg::mag24(rd_data);
	assign div_start = (state_q == ST_LD) && !pass;
	assign quot_ext  = pnc_pkg::SAMPLE_W'(quot);
	assign scaled    = neg_q ? pnc_pkg::sample_t'(~quot_ext + pnc_pkg::SAMPLE_W'(1)) : quot_ext;
	assign is_last   = CNT_W'(idx_q + CNT_W'(1)) == fill_q;

	pnc_store #(
		.DEPTH  (CHUNK_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[ADDR_W-1:0]),
		.wr_data (in_sample),
		.rd_en   (state_q == ST_RD),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	pnc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_mag),
		.divisor  (peak_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IN;
			fill_q     <= '0;
			idx_q      <= '0;
			peak_q     <= '0;
			neg_q      <= 1'b0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IN: begin
					if (wr_en) begin
						fill_q <= fill_q + CNT_W'(1);
						if (in_mag > peak_q) begin
							peak_q <= in_mag;
						end
					end
					if (in_req && s_axis_tlast) begin
						idx_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					neg_q      <= rd_data[pnc_pkg::SAMPLE_W-1];
					out_last_q <= is_last;
					if (pass) begin
						out_data_q <= rd_data;
						state_q    <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						out_data_q <= scaled;
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (out_last_q) begin
							fill_q  <= '0;
							peak_q  <= '0;
							state_q <= ST_IN;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: peak_normalize_chunk_unit
// Streams chunks of Q3.20 samples into the normalizer, predicts every emitted
// sample from an internal chunk model and compares the output stream in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 270;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		pnc_pkg::sample_t data;
		logic             last;
	} norm_out_t;

	typedef enum int {
		MIX_UNITY,
		MIX_FULL,
		MIX_EXTREME,
		MIX_QUIET
	} sample_mix_t;

	class chunk_norm_scoreboard;
		pnc_pkg::sample_t chunk_buf[$];
		pnc_pkg::sample_t peak;
		norm_out_t        expected_samples[$];
		int               errors;

		function new();
			peak   = '0;
			errors = 0;
		endfunction

		function pnc_pkg::sample_t scaled(input pnc_pkg::sample_t v);
			pnc_pkg::sample_t mag;
			logic [47:0]      quot;
			if (peak <= pnc_pkg::ONE_Q20) return v;
			mag  = v[pnc_pkg::SAMPLE_W-1] ? pnc_pkg::sample_t'(-v) : v;
			quot = {4'b0, mag, 20'b0} / {24'b0, peak};
			return v[pnc_pkg::SAMPLE_W-1] ? pnc_pkg::sample_t'(-quot[23:0]) : quot[23:0];
		endfunction

		function void note_sample(input pnc_pkg::sample_t data, input bit bad,
			input bit last);
			pnc_pkg::sample_t s;
			pnc_pkg::sample_t mag;
			norm_out_t        e;
			s   = bad ? '0 : data;
			mag = s[pnc_pkg::SAMPLE_W-1] ? pnc_pkg::sample_t'(-s) : s;
			// beyond the buffer depth the sample is dropped, peak untouched
			if (chunk_buf.size() < pnc_pkg::CHUNK_DEPTH) begin
				chunk_buf.insert(chunk_buf.size(), s);
				if (mag > peak) peak = mag;
			end
			if (last) begin
				foreach (chunk_buf[i]) begin
					e.data = scaled(chunk_buf[i]);
					e.last = (i == chunk_buf.size() - 1);
					expected_samples.insert(expected_samples.size(), e);
				end
				chunk_buf.delete();
				peak = '0;
			end
		endfunction

		function void check_sample(input pnc_pkg::sample_t data, input logic last);
			norm_out_t e;
			if (expected_samples.size() == 0) begin
				$error("unexpected sample_out %0d last_out %0b", $signed(data), last);
				errors++;
				return;
			end
			e = expected_samples[0];
			expected_samples.delete(0);
			if (data !== e.data) begin
				$error("sample_out expected %0d actual %0d", $signed(e.data), $signed(data));
				errors++;
			end
			if (last !== e.last) begin
				$error("last_out expected %0b actual %0b", e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	pnc_pkg::sample_t s_axis_tdata;
	logic             s_axis_tuser;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	pnc_pkg::sample_t m_axis_tdata;
	logic             m_axis_tlast;

	chunk_norm_scoreboard sb = new();
	int results_seen = 0;
	int idle_cycles  = 0;
	int items_sent   = 0;

	peak_normalize_chunk_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_sample(m_axis_tdata, m_axis_tlast);
			results_seen++;
		end
	end

	// watchdog: cycles with no request moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output side: random ready pattern, one long hold while a chunk drains
	initial begin
		int  n;
		int  r;
		bit  hold_done;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 9);
			if (!hold_done && results_seen >= 40 && m_axis_tvalid) begin
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
			end else if (r < 5) begin
				n = $urandom_range(1, 30);
				repeat (n) begin
					@(negedge clk);
					m_axis_tready <= 1'b1;
				end
			end else begin
				n = (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 50);
				repeat (n) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	task automatic send_sample(input pnc_pkg::sample_t s, input bit bad, input bit last,
		input bit with_gaps);
		int gap;
		gap = 0;
		if (with_gaps && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		s_axis_tuser  <= bad;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(s, bad, last);
		items_sent++;
	endtask

	function automatic pnc_pkg::sample_t pick_sample(input sample_mix_t mix);
		int v;
		case (mix)
			MIX_UNITY: begin
				v = int'($urandom_range(0, 2 * 1048576)) - 1048576;
			end
			MIX_FULL: begin
				v = int'($urandom);
			end
			MIX_EXTREME: begin
				case ($urandom_range(0, 5))
					0: v = 8388607;
					1: v = -8388608;
					2: v = 1048576;
					3: v = -1048576;
					4: v = 1048577;
					default: v = 0;
				endcase
			end
			default: begin
				v = int'($urandom_range(0, 2047)) - 1024;
			end
		endcase
		return pnc_pkg::sample_t'(v);
	endfunction

	task automatic send_chunk(input int len, input sample_mix_t mix, input bit with_gaps);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(mix), $urandom_range(0, 9) == 0, i == len - 1, with_gaps);
	endtask

	initial begin
		int          len;
		sample_mix_t mix;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, flagged sample, exact unity peak, just-over-unity peak
		send_sample(24'h7FFFFF, 1'b0, 1'b1, 1'b0);
		send_sample(24'h800000, 1'b0, 1'b1, 1'b0);
		send_sample(24'h7FFFFF, 1'b1, 1'b1, 1'b0);
		send_sample(pnc_pkg::ONE_Q20, 1'b0, 1'b0, 1'b0);
		send_sample(pnc_pkg::sample_t'(-pnc_pkg::ONE_Q20), 1'b0, 1'b0, 1'b0);
		send_sample(24'd12345, 1'b0, 1'b1, 1'b0);
		send_sample(pnc_pkg::ONE_Q20 + 24'd1, 1'b0, 1'b0, 1'b0);
		send_sample(24'h800000, 1'b1, 1'b0, 1'b0);
		send_sample(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
		send_sample(24'd1, 1'b0, 1'b1, 1'b0);
		send_sample(24'h800000, 1'b0, 1'b0, 1'b1);
		send_sample(24'h7FFFFF, 1'b0, 1'b0, 1'b1);
		send_sample(24'd0, 1'b0, 1'b0, 1'b1);
		send_sample(24'hFFFFFD, 1'b0, 1'b0, 1'b1);
		send_sample(24'd500000, 1'b0, 1'b1, 1'b1);
		send_sample(pnc_pkg::sample_t'(-(pnc_pkg::ONE_Q20 + 24'd1)), 1'b0, 1'b1, 1'b0);

		// overflowing chunk first: tlast lands on a dropped sample
		send_chunk(66, MIX_FULL, 1'b1);
		while (items_sent < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(63, 68) : $urandom_range(1, 12);
			mix = sample_mix_t'($urandom_range(0, 3));
			send_chunk(len, mix, $urandom_range(0, 3) != 0);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
